// File: design/tbeq_pkg.sv
// ----------------------------------------------------------------------------
// tbeq_pkg: shared types and constants of the three-band equaliser
// Holds the sequencer states, register indexes, widths of the shared
// multiplier and the divider, and the constants of the tanh clipper.
// ----------------------------------------------------------------------------
package tbeq_pkg;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_SCALE    = 14'b00000000000010,
		ST_SCALE_W  = 14'b00000000000100,
		ST_MLO      = 14'b00000000001000,
		ST_MHI      = 14'b00000000010000,
		ST_MFIN     = 14'b00000000100000,
		ST_CLIP     = 14'b00000001000000,
		ST_CLIP_SQ  = 14'b00000010000000,
		ST_DIV_ST   = 14'b00000100000000,
		ST_DIV_WAIT = 14'b00001000000000,
		ST_CLIP_AR  = 14'b00010000000000,
		ST_CLIP_Y   = 14'b00100000000000,
		ST_NEXT     = 14'b01000000000000,
		ST_DONE     = 14'b10000000000000
	} state_t;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PREAMP    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOW_COEF  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_COEF = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LOW_GAIN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MID_GAIN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_GAIN = 3'd5;
	localparam int CFG_W = 18;
	localparam int PRE_W = 17;

	// Multiply step codes: four low poles, four high poles, three band gains.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_LOW_FIRST  = 4'd0;
	localparam logic [OP_W-1:0] OP_LOW_LAST   = 4'd3;
	localparam logic [OP_W-1:0] OP_HIGH_FIRST = 4'd4;
	localparam logic [OP_W-1:0] OP_HIGH_LAST  = 4'd7;
	localparam logic [OP_W-1:0] OP_LOW_GAIN   = 4'd8;
	localparam logic [OP_W-1:0] OP_MID_GAIN   = 4'd9;
	localparam logic [OP_W-1:0] OP_HIGH_GAIN  = 4'd10;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = 128;

	localparam int CLIP_FRAC  = 20;
	localparam int RATIO_FRAC = 17;
	localparam int A_W        = 22;
	localparam int A2_W       = 2 * A_W;
	localparam int NUM_W      = 47;
	localparam int REM_W      = NUM_W + 1;
	localparam int QUOT_W     = RATIO_FRAC + 1;
	localparam int AR_W       = A_W + QUOT_W;
	localparam int Y_W        = AR_W + 15 - (CLIP_FRAC + RATIO_FRAC) + 1;
	localparam int CNT_W      = 5;
	localparam int TANH_K27   = 27;
	localparam int TANH_K9    = 9;
	localparam logic signed [15:0] OUT_MAX = 16'sd32767;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: design/tbeq_in_if.sv
// ----------------------------------------------------------------------------
// tbeq_in_if: input sample channel
// Carries one stereo sample pair with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbeq_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// File: design/tbeq_out_if.sv
// ----------------------------------------------------------------------------
// tbeq_out_if: output sample channel
// Carries one equalised, clipped stereo pair with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbeq_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: design/three_band_eq_soft_clip_top.sv
// A channel whose band sum clips hard skips the squaring, divide and ratio steps.
// A new stereo pair is taken only in the idle state, after the last result is handed on;
// the shared 32x24 multiplier forms each filter or gain product in the MLO, MHI and
// MFIN steps, and each divide waits in DIV_WAIT until the divider is done.
// Reset clears all filter poles, the input history, the datapath registers and the
// output valid flag, and loads the default gains and coefficients.
// ----------------------------------------------------------------------------
// three_band_eq_soft_clip_top: stereo three-band equaliser with tanh clipper
// A small sequencer drives one shared multiplier and a divider through the
// preamp, both filter cascades, band weighting and the rational tanh clipper.
// ----------------------------------------------------------------------------
module three_band_eq_soft_clip_top #(
	parameter int SAMPLE_BITS = 24,
	parameter int STATE_BITS  = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tbeq_in_if.sink                        samples,
	tbeq_out_if.source                     results,
	input  logic                           wr_en,
	input  logic [tbeq_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [tbeq_pkg::CFG_W-1:0]     wr_data
);
	import tbeq_pkg::*;

	localparam int SW    = STATE_BITS;
	localparam int SF    = SW - 18;
	localparam int SH    = (SAMPLE_BITS - 5) + 16 - SF;
	localparam int SH_R  = (SH >= 0) ? SH : 0;
	localparam int SH_L  = (SH < 0) ? -SH : 0;
	localparam int CL_R  = (SF >= CLIP_FRAC) ? SF - CLIP_FRAC : 0;
	localparam int CL_L  = (SF < CLIP_FRAC) ? CLIP_FRAC - SF : 0;
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [NUM_W-1:0] K27 = NUM_W'(TANH_K27) << (2 * CLIP_FRAC);

	function automatic logic signed [SW-1:0] sat_ext(input logic [SW:0] v);
		if (v[SW] != v[SW-1]) begin
			return v[SW] ? SMIN : SMAX;
		end
		return v[SW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		return sat_ext({a[SW-1], a} + {b[SW-1], b});
	endfunction

	function automatic logic signed [SW-1:0] ssub(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		return sat_ext({a[SW-1], a} - {b[SW-1], b});
	endfunction

	function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] x);
		return x[SW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [SW-1:0] from_mag(input logic neg,
			input logic [WIDE_W-1:0] m);
		logic [WIDE_W-1:0] lim;
		lim = WIDE_W'(SMAX);
		if (!neg) begin
			return (m > lim) ? SMAX : SW'(m);
		end
		if (m > lim + 1'b1) begin
			return SMIN;
		end
		return -SW'(m);
	endfunction

	// Configuration registers.
	logic [PRE_W-1:0] preamp_q;
	logic [CFG_W-1:0] low_coef_q, high_coef_q, low_gain_q, mid_gain_q, high_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamp_q    <= PRE_W'(61536);
			low_coef_q  <= CFG_W'(8212);
			high_coef_q <= CFG_W'(45707);
			low_gain_q  <= CFG_W'(78643);
			mid_gain_q  <= CFG_W'(65536);
			high_gain_q <= CFG_W'(52429);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PREAMP:    preamp_q    <= wr_data[PRE_W-1:0];
				REG_LOW_COEF:  low_coef_q  <= wr_data;
				REG_HIGH_COEF: high_coef_q <= wr_data;
				REG_LOW_GAIN:  low_gain_q  <= wr_data;
				REG_MID_GAIN:  mid_gain_q  <= wr_data;
				REG_HIGH_GAIN: high_gain_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Sequencer and datapath registers.
	state_t                  state_q;
	logic                    ch_q;
	logic [OP_W-1:0]         op_q;
	logic signed [SAMPLE_BITS-1:0] samp_q [2];
	logic signed [SW-1:0]    lp_q [8];
	logic signed [SW-1:0]    hp_q [8];
	logic signed [SW-1:0]    hist_q [2][3];
	logic signed [SW-1:0]    s_q, prev_q, sum_q, hband_q, mband_q;
	logic [SW-1:0]           mag_q;
	logic                    neg_q;
	logic [CFG_W-1:0]        c_q;
	logic [MUL_P_W-1:0]      lo_q;
	logic [A_W-1:0]          a_q;
	logic signed [15:0]      res_q [2];
	logic                    out_valid_q;
	logic signed [15:0]      out_left_q, out_right_q;

	// Shared units.
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_start;
	logic [NUM_W-1:0]   div_num, div_den;
	logic [QUOT_W-1:0]  div_quot;
	div_stat_t          div_st;

	tbeq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	tbeq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .quot(div_quot), .stat(div_st)
	);

	// Operand of the current multiply step.
	logic [2:0]           pidx;
	logic signed [SW-1:0] op_x;
	logic [CFG_W-1:0]     op_c;
	logic [SW-1:0]        op_mag;
	logic [63:0]          mag64;

	assign pidx   = {ch_q, op_q[1:0]};
	assign op_mag = mag_of(op_x);
	assign mag64  = 64'(mag_q);

	always_comb begin
		case (op_q) inside
			[OP_LOW_FIRST:OP_LOW_LAST]: begin
				op_x = ssub(prev_q, lp_q[pidx]);
				op_c = low_coef_q;
			end
			[OP_HIGH_FIRST:OP_HIGH_LAST]: begin
				op_x = ssub(prev_q, hp_q[pidx]);
				op_c = high_coef_q;
			end
			OP_LOW_GAIN: begin
				op_x = lp_q[{ch_q, 2'd3}];
				op_c = low_gain_q;
			end
			OP_MID_GAIN: begin
				op_x = mband_q;
				op_c = mid_gain_q;
			end
			default: begin
				op_x = hband_q;
				op_c = high_gain_q;
			end
		endcase
	end

	// Product of a coefficient step, floored to the state format and saturated.
	logic [WIDE_W-1:0]    prod_w, prod_q16;
	logic signed [SW-1:0] qv, pole_new, h_new, m_new;

	always_comb begin
		prod_w   = (WIDE_W'(mul_p) << 32) + WIDE_W'(lo_q);
		prod_q16 = prod_w >> 16;
		if (neg_q && (prod_w[15:0] != '0)) begin
			prod_q16 = prod_q16 + 1'b1;
		end
		qv       = from_mag(neg_q, prod_q16);
		pole_new = (op_q <= OP_LOW_LAST) ? sadd(lp_q[pidx], qv) : sadd(hp_q[pidx], qv);
		h_new    = ssub(hist_q[ch_q][2], pole_new);
		m_new    = ssub(hist_q[ch_q][2], sadd(h_new, lp_q[{ch_q, 2'd3}]));
	end

	// Preamp scaling of the current channel.
	logic signed [SAMPLE_BITS-1:0] samp_cur;
	logic [SAMPLE_BITS-1:0]        samp_mag;
	logic [WIDE_W-1:0]             sc_w, sc_q;
	logic signed [SW-1:0]          s_new;

	assign samp_cur = samp_q[ch_q];
	assign samp_mag = samp_cur[SAMPLE_BITS-1] ? (~samp_cur + 1'b1) : samp_cur;

	always_comb begin
		sc_w = WIDE_W'(mul_p) << SH_L;
		sc_q = sc_w >> SH_R;
		if (neg_q && ((sc_w & ((WIDE_W'(1) << SH_R) - 1'b1)) != '0)) begin
			sc_q = sc_q + 1'b1;
		end
		s_new = from_mag(neg_q, sc_q);
	end

	// Clipper arithmetic.
	logic [SW-1:0]   sum_mag;
	logic            hard_clip;
	logic [63:0]     a_wide;
	logic [A2_W-1:0] a2;
	logic [55:0]     ar_scaled;
	logic [Y_W-1:0]  y_raw;
	logic [15:0]     y_cap;

	assign sum_mag   = mag_of(sum_q);
	assign hard_clip = (SW + 1)'(sum_mag) > ((SW + 1)'(3) << SF);
	assign a_wide    = (64'(sum_mag) << CL_L) >> CL_R;
	assign a2        = mul_p[A2_W-1:0];
	assign div_num   = K27 + NUM_W'(a2);
	assign div_den   = K27 + (NUM_W'(a2) << 3) + NUM_W'(a2);
	assign ar_scaled = (56'(mul_p[AR_W-1:0]) << 15) - 56'(mul_p[AR_W-1:0]);
	assign y_raw     = Y_W'(ar_scaled >> (CLIP_FRAC + RATIO_FRAC));
	assign y_cap     = (y_raw > Y_W'(OUT_MAX)) ? 16'(OUT_MAX) : y_raw[15:0];
	assign div_start = state_q == ST_DIV_ST;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SCALE: begin
				mul_a = MUL_A_W'(samp_mag);
				mul_b = MUL_B_W'(preamp_q);
			end
			ST_MLO: begin
				mul_a = MUL_A_W'(op_mag);
				mul_b = MUL_B_W'(op_c);
			end
			ST_MHI: begin
				mul_a = mag64[63:32];
				mul_b = MUL_B_W'(c_q);
			end
			ST_CLIP_SQ: begin
				mul_a = MUL_A_W'(a_q);
				mul_b = MUL_B_W'(a_q);
			end
			ST_CLIP_AR: begin
				mul_a = MUL_A_W'(a_q);
				mul_b = MUL_B_W'(div_quot);
			end
			default: ;
		endcase
	end

	assign samples.ready     = state_q == ST_IDLE;
	assign results.valid     = out_valid_q;
	assign results.left_out  = out_left_q;
	assign results.right_out = out_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			op_q        <= '0;
			out_valid_q <= 1'b0;
			s_q         <= '0;
			prev_q      <= '0;
			sum_q       <= '0;
			hband_q     <= '0;
			mband_q     <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			c_q         <= '0;
			lo_q        <= '0;
			a_q         <= '0;
			res_q[0]    <= '0;
			res_q[1]    <= '0;
			for (int i = 0; i < 8; i++) begin
				lp_q[i] <= '0;
				hp_q[i] <= '0;
			end
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < 3; k++) begin
					hist_q[c][k] <= '0;
				end
			end
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || results.ready)) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						ch_q    <= 1'b0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					neg_q   <= samp_cur[SAMPLE_BITS-1];
					state_q <= ST_SCALE_W;
				end
				ST_SCALE_W: begin
					s_q     <= s_new;
					prev_q  <= s_new;
					op_q    <= OP_LOW_FIRST;
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					mag_q   <= op_mag;
					neg_q   <= op_x[SW-1];
					c_q     <= op_c;
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					lo_q    <= mul_p;
					state_q <= ST_MFIN;
				end
				ST_MFIN: begin
					case (op_q) inside
						[OP_LOW_FIRST:OP_LOW_LAST]: begin
							lp_q[pidx] <= pole_new;
							// The high cascade starts again from the scaled input.
							prev_q     <= (op_q == OP_LOW_LAST) ? s_q : pole_new;
						end
						[OP_HIGH_FIRST:OP_HIGH_LAST]: begin
							hp_q[pidx] <= pole_new;
							prev_q     <= pole_new;
							if (op_q == OP_HIGH_LAST) begin
								hband_q <= h_new;
								mband_q <= m_new;
							end
						end
						OP_LOW_GAIN: sum_q <= qv;
						OP_MID_GAIN: sum_q <= sadd(sum_q, qv);
						default: begin
							sum_q           <= sadd(sum_q, qv);
							hist_q[ch_q][2] <= hist_q[ch_q][1];
							hist_q[ch_q][1] <= hist_q[ch_q][0];
							hist_q[ch_q][0] <= s_q;
						end
					endcase
					if (op_q == OP_HIGH_GAIN) begin
						state_q <= ST_CLIP;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_CLIP: begin
					neg_q <= sum_q[SW-1];
					a_q   <= a_wide[A_W-1:0];
					if (hard_clip) begin
						res_q[ch_q] <= sum_q[SW-1] ? -OUT_MAX : OUT_MAX;
						state_q     <= ST_NEXT;
					end else begin
						state_q <= ST_CLIP_SQ;
					end
				end
				ST_CLIP_SQ:  state_q <= ST_DIV_ST;
				ST_DIV_ST:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_st.done && !div_st.busy) begin
						state_q <= ST_CLIP_AR;
					end
				end
				ST_CLIP_AR:  state_q <= ST_CLIP_Y;
				ST_CLIP_Y: begin
					res_q[ch_q] <= neg_q ? -$signed(y_cap) : $signed(y_cap);
					state_q     <= ST_NEXT;
				end
				ST_NEXT: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= ST_SCALE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || results.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			samp_q[0] <= samples.left_sample;
			samp_q[1] <= samples.right_sample;
		end
		if (state_q == ST_DONE && (!out_valid_q || results.ready)) begin
			out_left_q  <= res_q[0];
			out_right_q <= res_q[1];
		end
	end
endmodule

// File: design/tbeq_mul.sv
// ----------------------------------------------------------------------------
// tbeq_mul: shared unsigned multiplier
// One 32 by 24 bit product per cycle with a registered result.
// ----------------------------------------------------------------------------
module tbeq_mul (
	input  logic                         clk,
	input  logic [tbeq_pkg::MUL_A_W-1:0] a,
	input  logic [tbeq_pkg::MUL_B_W-1:0] b,
	output logic [tbeq_pkg::MUL_P_W-1:0] p
);
	import tbeq_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;
endmodule

// File: design/tbeq_div.sv
// ----------------------------------------------------------------------------
// tbeq_div: restoring divider for the clipper ratio
// Produces floor(num * 2^17 / den) one quotient bit per cycle; needs num <= den.
// ----------------------------------------------------------------------------
module tbeq_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tbeq_pkg::NUM_W-1:0]  num,
	input  logic [tbeq_pkg::NUM_W-1:0]  den,
	output logic [tbeq_pkg::QUOT_W-1:0] quot,
	output tbeq_pkg::div_stat_t         stat
);
	import tbeq_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  den_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              fits;
	logic [REM_W-1:0]  diff;

	assign diff = rem_q - REM_W'(den_q);
	assign fits = rem_q >= REM_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(QUOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The low dividend bits are all zero, so each step only doubles the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= REM_W'(num);
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			rem_q  <= fits ? {diff[REM_W-2:0], 1'b0} : {rem_q[REM_W-2:0], 1'b0};
		end
	end

	assign quot      = quot_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
endmodule

// File: tb/sv/tb_three_band_eq_soft_clip_top.sv
// ----------------------------------------------------------------------------
// tb_three_band_eq_soft_clip_top: self-checking bench of the stereo equaliser
// Drives stereo sample pairs with random gaps, stalls the result side at
// random, and compares each result with an in-bench model of the filters,
// band weighting and tanh clipper, or with zero after reset. Several register settings are visited.
// ----------------------------------------------------------------------------
module tb_three_band_eq_soft_clip_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tbeq_pkg::*;

	localparam int SB = 24;
	localparam int SW = 48;
	localparam int SF = SW - 18;
	localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;
	localparam int N_RANDOM = 520;
	localparam logic [REG_IDX_W-1:0] REG_UNKNOWN = 3'd7;

	typedef struct {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} pair_t;

	typedef struct {
		logic signed [SB-1:0] l;
		logic signed [SB-1:0] r;
		bit                   fixed;
		logic signed [15:0]   el;
		logic signed [15:0]   er;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	tbeq_in_if #(.SAMPLE_BITS(SB)) samples ();
	tbeq_out_if results ();

	three_band_eq_soft_clip_top dut (
		.clk(clk), .arst_n(arst_n), .samples(samples.sink), .results(results.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #1 clk = ~clk;

	// Model state and registers.
	longint unsigned pre_g, lo_c, hi_c, lo_g, mid_g, hi_g;
	longint lo_pole [8];
	longint hi_pole [8];
	longint hist [6];
	pair_t expected_pairs [$];
	int errors = 0;
	int n_results = 0;
	int n_clipped = 0;

	function automatic longint sat(input logic signed [127:0] v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return longint'(v);
	endfunction

	// floor(a*c/2^16), saturated.
	function automatic longint mul_coef(input longint a, input longint unsigned c);
		logic signed [127:0] p;
		p = 128'(signed'(a)) * $signed({64'd0, c});
		return sat(p >>> 16);
	endfunction

	function automatic longint scale_in(input logic signed [SB-1:0] x);
		logic signed [127:0] p;
		p = 128'(signed'(x)) * $signed({64'd0, pre_g});
		return sat(p >>> (SB - 5 + 16 - SF));
	endfunction

	function automatic logic signed [15:0] clip_tanh(input longint x);
		logic [63:0] m;
		logic [127:0] a, a2, num, den, r, y;
		m = (x < 0) ? -x : x;
		if (m > (64'd3 << SF)) return (x < 0) ? -16'sd32767 : 16'sd32767;
		a = m >> (SF - CLIP_FRAC);
		a2 = a * a;
		num = (128'd27 << (2 * CLIP_FRAC)) + a2;
		den = (128'd27 << (2 * CLIP_FRAC)) + 9 * a2;
		r = (num << RATIO_FRAC) / den;
		y = (a * r * 32767) >> (CLIP_FRAC + RATIO_FRAC);
		if (y > 32767) y = 32767;
		return (x < 0) ? -$signed(16'(y)) : $signed(16'(y));
	endfunction

	function automatic logic signed [15:0] eq_channel(input int ch, input logic signed [SB-1:0] x);
		longint s, prev, l, h, m, sum;
		s = scale_in(x);
		prev = s;
		for (int k = 0; k < 4; k++) begin
			lo_pole[ch*4+k] = sat(lo_pole[ch*4+k] + mul_coef(sat(prev - lo_pole[ch*4+k]), lo_c));
			prev = lo_pole[ch*4+k];
		end
		prev = s;
		for (int k = 0; k < 4; k++) begin
			hi_pole[ch*4+k] = sat(hi_pole[ch*4+k] + mul_coef(sat(prev - hi_pole[ch*4+k]), hi_c));
			prev = hi_pole[ch*4+k];
		end
		l = lo_pole[ch*4+3];
		h = sat(hist[ch*3+2] - hi_pole[ch*4+3]);
		m = sat(hist[ch*3+2] - sat(h + l));
		sum = sat(sat(mul_coef(l, lo_g) + mul_coef(m, mid_g)) + mul_coef(h, hi_g));
		hist[ch*3+2] = hist[ch*3+1];
		hist[ch*3+1] = hist[ch*3];
		hist[ch*3] = s;
		return clip_tanh(sum);
	endfunction

	function automatic pair_t predict_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		pair_t p;
		p.left_out = eq_channel(0, l);
		p.right_out = eq_channel(1, r);
		return p;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input longint unsigned v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= CFG_W'(v);
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_PREAMP:    pre_g = v & 64'h1FFFF;
			REG_LOW_COEF:  lo_c = v & 64'h3FFFF;
			REG_HIGH_COEF: hi_c = v & 64'h3FFFF;
			REG_LOW_GAIN:  lo_g = v & 64'h3FFFF;
			REG_MID_GAIN:  mid_g = v & 64'h3FFFF;
			REG_HIGH_GAIN: hi_g = v & 64'h3FFFF;
			default: ;
		endcase
	endtask

	// The request stays valid after acceptance until the next gap or drain lowers it.
	task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.left_sample <= l;
		samples.right_sample <= r;
		expected_pairs.push_back(predict_pair(l, r));
		do @(posedge clk); while (!samples.ready);
	endtask

	// Silent input after reset must give zero; the expectation is already queued.
	task automatic send_pair_fixed(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
		int gap;
		gap = $urandom_range(0, 19);
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.left_sample <= l;
		samples.right_sample <= r;
		do @(posedge clk); while (!samples.ready);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return SB'($urandom);
			1: return SB'($signed($urandom_range(0, 8192)) - 4096);
			2: return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
			default: return SB'($signed($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	// Result side: random stalls, compare in order.
	initial begin
		int stall;
		pair_t e;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
			n_results++;
			if (expected_pairs.size() == 0) begin
				$error("result with no pending request: %0d %0d", results.left_out, results.right_out);
				errors++;
			end else begin
				e = expected_pairs.pop_front();
				if (e.left_out == 16'sd32767 || e.left_out == -16'sd32767) n_clipped++;
				if (results.left_out !== e.left_out) begin
					$error("left_out expected %0d actual %0d", e.left_out, results.left_out);
					errors++;
				end
				if (results.right_out !== e.right_out) begin
					$error("right_out expected %0d actual %0d", e.right_out, results.right_out);
					errors++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("three_band_eq_soft_clip_top: mismatch");
		$finish;
	end

	initial begin
		row_t dir [$];
		logic signed [SB-1:0] pos_max, neg_max;
		samples.valid = 1'b0;
		samples.left_sample = '0;
		samples.right_sample = '0;
		pre_g = 61536; lo_c = 8212; hi_c = 45707; lo_g = 78643; mid_g = 65536; hi_g = 52429;
		foreach (lo_pole[i]) begin lo_pole[i] = 0; hi_pole[i] = 0; end
		foreach (hist[i]) hist[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		pos_max = {1'b0, {(SB-1){1'b1}}};
		neg_max = {1'b1, {(SB-1){1'b0}}};

		// Directed: silence after reset gives zero; full-scale steps and small values.
		dir.push_back('{0, 0, 1, 0, 0});
		dir.push_back('{0, 0, 1, 0, 0});
		dir.push_back('{pos_max, neg_max, 0, 0, 0});
		dir.push_back('{pos_max, neg_max, 0, 0, 0});
		dir.push_back('{pos_max, neg_max, 0, 0, 0});
		dir.push_back('{pos_max, neg_max, 0, 0, 0});
		dir.push_back('{neg_max, pos_max, 0, 0, 0});
		dir.push_back('{1, -1, 0, 0, 0});
		dir.push_back('{-24'sd524288, 24'sd524288, 0, 0, 0});
		dir.push_back('{24'sd1572864, -24'sd1572864, 0, 0, 0});
		dir.push_back('{-1, 1, 0, 0, 0});
		dir.push_back('{24'sh555555, -24'sh2AAAAA, 0, 0, 0});
		foreach (dir[i]) begin
			if (dir[i].fixed) begin
				void'(predict_pair(dir[i].l, dir[i].r));
				expected_pairs.push_back('{dir[i].el, dir[i].er});
				send_pair_fixed(dir[i].l, dir[i].r);
			end else
				send_pair(dir[i].l, dir[i].r);
		end
		drain();

		// Register extremes, including above-range values and an unknown index.
		write_reg(REG_PREAMP, 65536); write_reg(REG_LOW_COEF, 131072);
		write_reg(REG_HIGH_COEF, 0); write_reg(REG_LOW_GAIN, 196608);
		write_reg(REG_MID_GAIN, 0); write_reg(REG_HIGH_GAIN, 196608);
		write_reg(REG_UNKNOWN, 12345);
		for (int i = 0; i < 8; i++) send_pair(i[0] ? pos_max : neg_max, rand_sample());
		drain();
		write_reg(REG_PREAMP, 131071); write_reg(REG_LOW_COEF, 262143);
		write_reg(REG_HIGH_COEF, 262143); write_reg(REG_LOW_GAIN, 262143);
		write_reg(REG_MID_GAIN, 262143); write_reg(REG_HIGH_GAIN, 0);
		for (int i = 0; i < 8; i++) send_pair(rand_sample(), rand_sample());
		drain();
		write_reg(REG_PREAMP, 0);
		for (int i = 0; i < 3; i++) send_pair(rand_sample(), rand_sample());
		drain();

		// Random phases, each with fresh register values.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_PREAMP, $urandom_range(0, 65536));
			write_reg(REG_LOW_COEF, $urandom_range(0, 131072));
			write_reg(REG_HIGH_COEF, $urandom_range(0, 131072));
			write_reg(REG_LOW_GAIN, $urandom_range(0, 196608));
			write_reg(REG_MID_GAIN, $urandom_range(0, 196608));
			write_reg(REG_HIGH_GAIN, $urandom_range(0, 196608));
			for (int i = 0; i < N_RANDOM / 5; i++) send_pair(rand_sample(), rand_sample());
			drain();
		end

		$display("Checked %0d stereo results over several register settings,", n_results);
		$display("%0d of them at the clip limit on the left channel.", n_clipped);
		if (errors == 0)
			$display("three_band_eq_soft_clip_top: match");
		else
			$display("three_band_eq_soft_clip_top: mismatch");
		$finish;
	end

endmodule
